// ===== rtl/core/pc_sample_profile_histogram_top_assert.svh =====
// Assertion macros shared by the profiler RTL, compiled out when NO_ASSERTIONS is set.
`ifndef PC_SAMPLE_PROFILE_HISTOGRAM_TOP_ASSERT_SVH
`define PC_SAMPLE_PROFILE_HISTOGRAM_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PCPROF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PCPROF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCPROF_ASSERT_IMP(label, ante, cons, msg)
`define PCPROF_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/pcprof_pkg.sv =====
// Shared types, field widths and codes of the program-counter sampling profiler.
package pcprof_pkg;

    localparam int ACT_W      = 3;
    localparam int VAL_W      = 32;
    localparam int BC_W       = 16;
    localparam int EIDX_W     = 11;
    localparam int ERR_W      = 3;
    localparam int CNT_W      = 32;
    localparam int SF_W       = 2;
    localparam int TS_W       = 11;

    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 80;

    localparam logic [ACT_W-1:0] ACT_START  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WORD   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SAMPLE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ENABLE = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK         = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NOT_LOADED = 3'd1;
    localparam logic [ERR_W-1:0] ERR_NO_SPACE   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_LENGTH = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BUSY       = 3'd4;
    localparam logic [ERR_W-1:0] ERR_INVALID    = 3'd5;

    localparam int FLAG_ENABLED = 0;
    localparam int FLAG_LOADED  = 1;

    localparam logic [BC_W-1:0] MIN_BYTES = 16'd12;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [VAL_W-1:0]  value;
        logic              supervisor;
        logic [BC_W-1:0]   byte_count;
        logic [EIDX_W-1:0] entry_index;
    } req_t;

    // First member sits in the top bits, so error lands in the low bits.
    typedef struct packed {
        logic [TS_W-1:0]  table_size;
        logic [SF_W-1:0]  state_flags;
        logic [CNT_W-1:0] count_out;
        logic [VAL_W-1:0] symbol_out;
        logic [ERR_W-1:0] error;
    } res_t;

endpackage

// ===== rtl/core/pcprof_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module pcprof_ram
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pcprof_ctrl.sv =====
// Sequencer of the profiler: table load, binary search, counter update and readback.
`include "pc_sample_profile_histogram_top_assert.svh"

module pcprof_ctrl
    import pcprof_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024,
    parameter int ADDRESS_BITS  = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t req,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_AW = $clog2(TABLE_ENTRIES + 1);
    localparam int SZ_W   = CNT_AW;
    localparam int SYM_W  = ADDRESS_BITS;
    localparam int CMP_W  = (SZ_W > EIDX_W) ? SZ_W : EIDX_W;
    localparam int MAX_BYTES = 4 * TABLE_ENTRIES;
    localparam logic [CNT_AW-1:0] CLR_LAST = CNT_AW'(TABLE_ENTRIES);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_INIT   = 3'd0;
    localparam logic [ST_W-1:0] ST_IDLE   = 3'd1;
    localparam logic [ST_W-1:0] ST_CLEAR  = 3'd2;
    localparam logic [ST_W-1:0] ST_SEARCH = 3'd3;
    localparam logic [ST_W-1:0] ST_CNT_RD = 3'd4;
    localparam logic [ST_W-1:0] ST_CNT_WR = 3'd5;
    localparam logic [ST_W-1:0] ST_READ   = 3'd6;
    localparam logic [ST_W-1:0] ST_DONE   = 3'd7;

    logic [ST_W-1:0]   state_reg, state_next;
    logic [SF_W-1:0]   flags_reg, flags_next;
    logic [SZ_W-1:0]   size_reg, size_next;
    logic [SZ_W-1:0]   load_pos_reg, load_pos_next;
    logic              load_active_reg, load_active_next;
    logic              load_unsorted_reg, load_unsorted_next;
    logic [SYM_W-1:0]  prev_word_reg, prev_word_next;
    logic [CNT_AW-1:0] clear_idx_reg, clear_idx_next;

    logic [SZ_W-1:0]   lo_reg, lo_next;
    logic [SZ_W-1:0]   hi_reg, hi_next;
    logic [SZ_W-1:0]   mid_reg, mid_next;
    logic [SYM_W-1:0]  pc_reg, pc_next;
    logic [CNT_AW-1:0] cnt_idx_reg, cnt_idx_next;
    logic              sym_ok_reg, sym_ok_next;
    logic              cnt_ok_reg, cnt_ok_next;
    logic [ERR_W-1:0]  err_reg, err_next;
    logic [VAL_W-1:0]  sym_res_reg, sym_res_next;
    logic [CNT_W-1:0]  cnt_res_reg, cnt_res_next;

    logic              sym_we;
    logic [IDX_W-1:0]  sym_waddr;
    logic [SYM_W-1:0]  sym_wdata;
    logic [IDX_W-1:0]  sym_raddr;
    logic [SYM_W-1:0]  sym_rdata;
    logic              cnt_we;
    logic [CNT_AW-1:0] cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [CNT_AW-1:0] cnt_raddr;
    logic [CNT_W-1:0]  cnt_rdata;

    logic [63:0]       value_wide;
    logic [SYM_W-1:0]  word_val;
    logic [63:0]       sym_wide;
    logic [CMP_W-1:0]  idx_c;
    logic [CMP_W-1:0]  size_c;
    logic [SZ_W-1:0]   start_mid;
    logic [SZ_W-1:0]   pos_inc;
    logic              srch_ge;
    logic [SZ_W-1:0]   srch_lo;
    logic [SZ_W-1:0]   srch_hi;
    logic [SZ_W:0]     srch_sum;
    logic [SZ_W-1:0]   srch_mid;
    logic              bad_len;

    pcprof_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (SYM_W)
    ) u_sym_ram (
        .clk   (clk),
        .we    (sym_we),
        .waddr (sym_waddr),
        .wdata (sym_wdata),
        .raddr (sym_raddr),
        .rdata (sym_rdata)
    );

    pcprof_ram #(
        .DEPTH (TABLE_ENTRIES + 1),
        .WIDTH (CNT_W)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Incoming words and pcs are masked to the address width.
    assign value_wide = 64'(req.value);
    assign word_val   = value_wide[SYM_W-1:0];
    assign sym_wide   = 64'(sym_rdata);

    assign idx_c     = CMP_W'(req.entry_index);
    assign size_c    = CMP_W'(size_reg);
    assign start_mid = size_reg >> 1;
    assign pos_inc   = load_pos_reg + SZ_W'(1);
    assign bad_len   = (req.byte_count[1:0] != 2'b00) || (req.byte_count < MIN_BYTES);

    // One search step per cycle: the entry read last cycle decides the half.
    assign srch_ge  = pc_reg >= sym_rdata;
    assign srch_lo  = srch_ge ? mid_reg : lo_reg;
    assign srch_hi  = srch_ge ? hi_reg : mid_reg;
    assign srch_sum = {1'b0, srch_lo} + {1'b0, srch_hi};
    assign srch_mid = srch_sum[SZ_W:1];

    always_comb
    begin
        state_next         = state_reg;
        flags_next         = flags_reg;
        size_next          = size_reg;
        load_pos_next      = load_pos_reg;
        load_active_next   = load_active_reg;
        load_unsorted_next = load_unsorted_reg;
        prev_word_next     = prev_word_reg;
        clear_idx_next     = clear_idx_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        mid_next           = mid_reg;
        pc_next            = pc_reg;
        cnt_idx_next       = cnt_idx_reg;
        sym_ok_next        = sym_ok_reg;
        cnt_ok_next        = cnt_ok_reg;
        err_next           = err_reg;
        sym_res_next       = sym_res_reg;
        cnt_res_next       = cnt_res_reg;

        sym_we    = 1'b0;
        sym_waddr = load_pos_reg[IDX_W-1:0];
        sym_wdata = word_val;
        sym_raddr = mid_reg[IDX_W-1:0];
        cnt_we    = 1'b0;
        cnt_waddr = clear_idx_reg;
        cnt_wdata = '0;
        cnt_raddr = cnt_idx_reg;

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clear_idx_reg;
                cnt_wdata = '0;
                if (clear_idx_reg == CLR_LAST)
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
                else
                begin
                    clear_idx_next = clear_idx_reg + CNT_AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next   = ST_DONE;
                    err_next     = ERR_OK;
                    sym_res_next = '0;
                    cnt_res_next = '0;
                    case (req.action)
                        ACT_START:
                        begin
                            if (32'(req.byte_count) > 32'(MAX_BYTES))
                            begin
                                err_next = ERR_NO_SPACE;
                            end
                            else if (bad_len)
                            begin
                                err_next = ERR_BAD_LENGTH;
                            end
                            else if (flags_reg[FLAG_ENABLED])
                            begin
                                err_next = ERR_BUSY;
                            end
                            else
                            begin
                                size_next          = SZ_W'(req.byte_count >> 2);
                                flags_next         = '0;
                                load_pos_next      = '0;
                                load_active_next   = 1'b1;
                                load_unsorted_next = 1'b0;
                                prev_word_next     = '0;
                                clear_idx_next     = '0;
                                state_next         = ST_CLEAR;
                            end
                        end

                        ACT_WORD:
                        begin
                            if (!load_active_reg || (load_pos_reg >= size_reg))
                            begin
                                err_next = ERR_BAD_LENGTH;
                            end
                            else
                            begin
                                sym_we         = 1'b1;
                                prev_word_next = word_val;
                                load_pos_next  = pos_inc;
                                if ((load_pos_reg != '0) && (word_val < prev_word_reg))
                                begin
                                    load_unsorted_next = 1'b1;
                                end
                                if (pos_inc == size_reg)
                                begin
                                    load_active_next = 1'b0;
                                    if (load_unsorted_next)
                                    begin
                                        flags_next = '0;
                                        err_next   = ERR_INVALID;
                                    end
                                    else
                                    begin
                                        flags_next = SF_W'(1) << FLAG_LOADED;
                                    end
                                end
                            end
                        end

                        ACT_SAMPLE:
                        begin
                            if (flags_reg[FLAG_ENABLED])
                            begin
                                if (!req.supervisor)
                                begin
                                    cnt_idx_next = size_reg;
                                    state_next   = ST_CNT_RD;
                                end
                                else
                                begin
                                    pc_next  = word_val;
                                    lo_next  = '0;
                                    hi_next  = size_reg;
                                    mid_next = start_mid;
                                    if (start_mid == '0)
                                    begin
                                        cnt_idx_next = '0;
                                        state_next   = ST_CNT_RD;
                                    end
                                    else
                                    begin
                                        sym_raddr  = start_mid[IDX_W-1:0];
                                        state_next = ST_SEARCH;
                                    end
                                end
                            end
                        end

                        ACT_READ:
                        begin
                            if (!flags_reg[FLAG_LOADED])
                            begin
                                err_next = ERR_NOT_LOADED;
                            end
                            else
                            begin
                                sym_raddr   = idx_c[IDX_W-1:0];
                                cnt_raddr   = idx_c[CNT_AW-1:0];
                                sym_ok_next = idx_c < size_c;
                                cnt_ok_next = idx_c <= size_c;
                                state_next  = ST_READ;
                            end
                        end

                        ACT_ENABLE:
                        begin
                            if (flags_reg[FLAG_LOADED])
                            begin
                                flags_next = {1'b1, req.value[0]};
                            end
                            else
                            begin
                                err_next = ERR_INVALID;
                            end
                        end

                        default:
                        begin
                            err_next = ERR_INVALID;
                        end
                    endcase
                end
            end

            ST_SEARCH:
            begin
                lo_next  = srch_lo;
                hi_next  = srch_hi;
                mid_next = srch_mid;
                if (srch_mid == srch_lo)
                begin
                    cnt_idx_next = CNT_AW'(srch_mid);
                    state_next   = ST_CNT_RD;
                end
                else
                begin
                    sym_raddr = srch_mid[IDX_W-1:0];
                end
            end

            ST_CNT_RD:
            begin
                cnt_raddr  = cnt_idx_reg;
                state_next = ST_CNT_WR;
            end

            ST_CNT_WR:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = cnt_idx_reg;
                cnt_wdata  = cnt_rdata + CNT_W'(1);
                state_next = ST_DONE;
            end

            ST_READ:
            begin
                sym_res_next = sym_ok_reg ? sym_wide[VAL_W-1:0] : '0;
                cnt_res_next = cnt_ok_reg ? cnt_rdata : '0;
                state_next   = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_INIT;
            flags_reg         <= '0;
            size_reg          <= '0;
            load_pos_reg      <= '0;
            load_active_reg   <= 1'b0;
            load_unsorted_reg <= 1'b0;
            prev_word_reg     <= '0;
            clear_idx_reg     <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            flags_reg         <= flags_next;
            size_reg          <= size_next;
            load_pos_reg      <= load_pos_next;
            load_active_reg   <= load_active_next;
            load_unsorted_reg <= load_unsorted_next;
            prev_word_reg     <= prev_word_next;
            clear_idx_reg     <= clear_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        pc_reg      <= pc_next;
        cnt_idx_reg <= cnt_idx_next;
        sym_ok_reg  <= sym_ok_next;
        cnt_ok_reg  <= cnt_ok_next;
        err_reg     <= err_next;
        sym_res_reg <= sym_res_next;
        cnt_res_reg <= cnt_res_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb
    begin
        res.error       = err_reg;
        res.symbol_out  = sym_res_reg;
        res.count_out   = cnt_res_reg;
        res.state_flags = flags_reg;
        res.table_size  = TS_W'(size_reg);
    end

    `PCPROF_ASSERT_IMP(a_search_window, (state_reg == ST_SEARCH),
        (lo_reg < mid_reg) && (mid_reg < hi_reg), "search midpoint left its window")
    `PCPROF_ASSERT_IMP(a_load_in_range, load_active_reg,
        load_pos_reg < size_reg, "load position ran past the table size")
    `PCPROF_ASSERT_IMP(a_enable_needs_table, flags_reg[FLAG_ENABLED],
        flags_reg[FLAG_LOADED], "profiling enabled without a loaded table")
    `PCPROF_ASSERT_IMP(a_count_index, (state_reg == ST_CNT_WR),
        cnt_idx_reg <= CNT_AW'(size_reg), "counter update beyond the extra counter")
    `PCPROF_ASSERT_NXT(a_clear_flags, (state_reg == ST_CLEAR),
        flags_reg == '0, "flags changed during the counter clearing pass")

endmodule

// ===== rtl/core/pc_sample_profile_histogram_top.sv =====
// A transaction runs from idle to the done state: a read passes the read state, an enabled
// user sample updates the extra counter, a supervisor one first runs a binary search (one
// search step a cycle). A good start load first clears all TABLE_ENTRIES + 1 counters.
// One transaction is in work at a time: no new input is taken until its result enters the
// output register, which holds a result while the next input is taken. After reset the
// clearing pass runs with s_axis_tready low; flags, size and load state come up zero.
module pc_sample_profile_histogram_top
    import pcprof_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024,
    parameter int ADDRESS_BITS  = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // value[31:0], byte_count[47:32], entry_index[58:48], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action[2:0], supervisor[3]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // error[2:0], symbol_out[34:3], count_out[66:35], state_flags[68:67],
    // table_size[79:69]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    req_t req;
    res_t res;
    logic res_valid;
    logic res_ready;
    logic out_valid_reg, out_valid_next;
    res_t out_res_reg;

    assign req.action      = s_axis_tuser[2:0];
    assign req.supervisor  = s_axis_tuser[3];
    assign req.value       = s_axis_tdata[31:0];
    assign req.byte_count  = s_axis_tdata[47:32];
    assign req.entry_index = s_axis_tdata[58:48];

    pcprof_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The output register frees up in the same cycle its transaction completes.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.table_size, out_res_reg.state_flags,
                            out_res_reg.count_out, out_res_reg.symbol_out,
                            out_res_reg.error};

endmodule
